// ===== rtl/core/pts_pkg.sv =====
// ----------------------------------------------------------------------------
// pts_pkg: shared types and constants of the priority task scheduler
// Task count, index widths, item codes, cell command and scan token types.
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam int NUM_TASKS = 8;
  localparam int TASK_W    = (NUM_TASKS > 2) ? $clog2(NUM_TASKS) : 1;
  // Compare width: wide enough for a cell index and for the 3-bit fields
  localparam int CMP_W     = (TASK_W > 3) ? TASK_W : 3;
  localparam int CNT_W     = 16;
  localparam int PRI_W     = 8;

  // Item kinds carried on tuser
  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_LOAD = 1'b1;

  // Register map
  localparam logic [2:0] ADDR_TASKS_IN_USE = 3'd0;
  localparam logic [2:0] TASKS_IN_USE_RST  = 3'd7;

  // Broadcast to every cell
  typedef struct packed {
    logic             load;
    logic             dec;
    logic             refill;
    logic [CMP_W-1:0] sel;      // task addressed by load or dec
    logic [CMP_W-1:0] n_used;   // highest in-use index
    logic [CNT_W-1:0] cnt;
    logic [PRI_W-1:0] pri;
  } cell_cmd_t;

  // Best candidate so far, handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic [TASK_W-1:0] idx;
    logic [CNT_W-1:0]  cnt;
  } scan_tok_t;

endpackage

// ===== rtl/core/pts_cell.sv =====
// ----------------------------------------------------------------------------
// pts_cell: one task slot of the scheduler chain
// Holds a task's counter and priority, and forwards the scan candidate.
// ----------------------------------------------------------------------------
module pts_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [pts_pkg::CMP_W-1:0] cell_idx_i,
  input  pts_pkg::cell_cmd_t      cmd_i,
  input  pts_pkg::scan_tok_t      tok_i,
  output pts_pkg::scan_tok_t      tok_o,
  output logic [pts_pkg::CNT_W-1:0] cnt_o
);
  import pts_pkg::*;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [PRI_W-1:0] pri_q, pri_d;
  scan_tok_t        tok_q, tok_d;
  logic             hit, in_use;
  logic [CNT_W:0]   refill_sum;

  assign hit        = (cmd_i.sel == cell_idx_i);
  assign in_use     = (cell_idx_i <= cmd_i.n_used);
  assign refill_sum = {2'b00, cnt_q[CNT_W-1:1]} + {{(CNT_W+1-PRI_W){1'b0}}, pri_q};

  always_comb begin
    cnt_d = cnt_q;
    pri_d = pri_q;
    priority if (cmd_i.load && hit) begin
      cnt_d = cmd_i.cnt;
      pri_d = cmd_i.pri;
    end else if (cmd_i.dec && hit) begin
      if (cnt_q != '0) begin
        cnt_d = cnt_q - CNT_W'(1);
      end
    end else if (cmd_i.refill && in_use) begin
      // saturate at the top of the counter range
      cnt_d = refill_sum[CNT_W] ? '1 : refill_sum[CNT_W-1:0];
    end
  end

  // Strict compare: an earlier (higher) index keeps a tie
  always_comb begin
    tok_d       = tok_i;
    if (in_use && (cnt_q > tok_i.cnt)) begin
      tok_d.idx = cell_idx_i[TASK_W-1:0];
      tok_d.cnt = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      pri_q       <= '0;
      tok_q.valid <= 1'b0;
      tok_q.idx   <= '0;
      tok_q.cnt   <= '0;
    end else begin
      cnt_q <= cnt_d;
      pri_q <= pri_d;
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;
  assign cnt_o = cnt_q;

endmodule

// ===== rtl/core/priority_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// priority_task_scheduler: counter and priority based task scheduler
// Tasks live in a chain of cells; a schedule sends a candidate down the chain.
// ----------------------------------------------------------------------------
//
//  channel   direction  tdata / tuser                                  request
//  s_axis    in         tdata: task_index, counter_value, priority     load or tick
//                       tuser: mode (0 tick, 1 load)
//  m_axis    out        tdata: current_task, switched, current_counter, one result
//                       no_runnable
//  apb       in/out     register 0 at byte 0: tasks_in_use             config
//
//  A load, or a tick that schedules nothing, goes straight to the output state. A
//  schedule runs one pass down the chain of NUM_TASKS-1 cells; when every
//  counter is empty, a refill pass and a second scan pass follow.
//  One request is in flight at a time; the result sits in an output register
//  and the next request is taken while it waits. A stalled result holds the
//  finished request in its last state until m_axis_tready rises.
//  Reset clears every counter and priority, selects the idle task and sets
//  tasks_in_use to 7.
// ----------------------------------------------------------------------------
module priority_task_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [2:0] task_index, [18:3] counter_value,
                                      // [26:19] priority_value, rest zero
  input  logic [0:0]  s_axis_tuser,   // [0] mode
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [2:0] current_task, [3] switched,
                                      // [19:4] current_counter, [20] no_runnable
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pts_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN1,
    ST_REFILL,
    ST_SCAN2,
    ST_OUT
  } state_e;

  state_e            state_q;
  logic [2:0]        tasks_in_use_q;
  logic [TASK_W-1:0] running_q, old_q;
  logic              none_q, launch_q;
  logic              m_valid_q;
  logic [23:0]       m_data_q;

  logic              s_acc, cfg_wr, out_free;
  logic              tick_sched, launch_d;
  logic [2:0]        in_index;
  logic [CNT_W-1:0]  in_cnt, run_cnt;
  logic [PRI_W-1:0]  in_pri;
  logic [CMP_W-1:0]  n_used;
  cell_cmd_t         cmd;
  scan_tok_t         launch_tok;
  scan_tok_t         tok_w [1:NUM_TASKS-1];
  logic [CNT_W-1:0]  cnt_w [NUM_TASKS];

  // Unpack the request
  assign in_index = s_axis_tdata[2:0];
  assign in_cnt   = s_axis_tdata[18:3];
  assign in_pri   = s_axis_tdata[26:19];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  // APB: one register, always ready
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_TASKS_IN_USE);
  assign prdata = (paddr == ADDR_TASKS_IN_USE) ? {29'd0, tasks_in_use_q} : 32'd0;

  // Clamp the in-use count to the tasks that exist
  always_comb begin
    if (CMP_W'(tasks_in_use_q) > CMP_W'(NUM_TASKS - 1)) begin
      n_used = CMP_W'(NUM_TASKS - 1);
    end else begin
      n_used = CMP_W'(tasks_in_use_q);
    end
  end

  // Idle task slot: counter fixed at zero, no cell
  assign cnt_w[0] = '0;
  assign run_cnt  = cnt_w[running_q];

  // A tick schedules when idle or when the running slice runs out on it
  assign tick_sched = (running_q == '0) || (run_cnt <= CNT_W'(1));
  // Launch a candidate after a scheduling tick or after a refill pass
  assign launch_d   = (state_q == ST_REFILL) ||
                      (s_acc && (s_axis_tuser[0] == MODE_TICK) && tick_sched);

  // Cell commands: load and decrement fire on the accepting edge
  always_comb begin
    cmd.load   = s_acc && (s_axis_tuser[0] == MODE_LOAD);
    cmd.dec    = s_acc && (s_axis_tuser[0] == MODE_TICK) && (running_q != '0);
    cmd.refill = (state_q == ST_REFILL);
    cmd.sel    = cmd.dec ? CMP_W'(running_q) : CMP_W'(in_index);
    cmd.n_used = n_used;
    cmd.cnt    = in_cnt;
    cmd.pri    = in_pri;
  end

  // Fresh candidate enters at the highest cell
  assign launch_tok.valid = launch_q;
  assign launch_tok.idx   = '0;
  assign launch_tok.cnt   = '0;

  for (genvar i = 1; i < NUM_TASKS; i++) begin : g_cell
    scan_tok_t tok_in;
    if (i == NUM_TASKS - 1) begin : g_head
      assign tok_in = launch_tok;
    end else begin : g_link
      assign tok_in = tok_w[i+1];
    end
    pts_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (CMP_W'(i)),
      .cmd_i      (cmd),
      .tok_i      (tok_in),
      .tok_o      (tok_w[i]),
      .cnt_o      (cnt_w[i])
    );
  end

  // Sequencer, task state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      tasks_in_use_q <= TASKS_IN_USE_RST;
      running_q      <= '0;
      old_q          <= '0;
      none_q         <= 1'b0;
      launch_q       <= 1'b0;
      m_valid_q      <= 1'b0;
      m_data_q       <= '0;
    end else begin
      launch_q <= launch_d;
      if (cfg_wr) begin
        tasks_in_use_q <= pwdata[2:0];
      end
      // drop a taken result unless a new one is loaded in its place
      if (m_valid_q && m_axis_tready && (state_q != ST_OUT)) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_acc) begin
            old_q  <= running_q;
            none_q <= 1'b0;
            if (s_axis_tuser[0] == MODE_LOAD) begin
              state_q <= ST_OUT;
            end else if (tick_sched) begin
              // counter runs out on this tick, or idle: schedule
              state_q <= ST_SCAN1;
            end else begin
              state_q <= ST_OUT;
            end
          end
        end
        ST_SCAN1: begin
          if (tok_w[1].valid) begin
            if (tok_w[1].idx != '0) begin
              running_q <= tok_w[1].idx;
              state_q   <= ST_OUT;
            end else begin
              state_q <= ST_REFILL;
            end
          end
        end
        ST_REFILL: begin
          state_q <= ST_SCAN2;
        end
        ST_SCAN2: begin
          if (tok_w[1].valid) begin
            if (tok_w[1].idx != '0) begin
              running_q <= tok_w[1].idx;
            end else begin
              none_q <= 1'b1;
            end
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          // hold until the result register is free
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {3'd0, none_q, run_cnt, (running_q != old_q),
                          3'(CMP_W'(running_q))};
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// ===== rtl/core/pts_checker.sv =====
// ----------------------------------------------------------------------------
// pts_checker: port-level checks of the priority task scheduler
// Result consistency and result-channel hold, bound to the top level.
// ----------------------------------------------------------------------------
module pts_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // A switch always lands on a real task
  a_switch_task: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[2:0] != 3'd0)
    else $error("switched to the idle task");

  // A freshly picked task has time left
  a_switch_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[19:4] != 16'd0)
    else $error("switched to a task with an empty counter");

  // Nothing to run: no switch and the kept task is out of time
  a_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[20] |-> !m_axis_tdata[3] && m_axis_tdata[19:4] == 16'd0)
    else $error("no_runnable with a switch or a live counter");

endmodule

bind priority_task_scheduler pts_checker u_pts_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
